@@ rtl/core/tsc_pkg.sv @@
// shared types and constants for the tick-to-nanosecond scale factor block
// used by tsc_divider and tsc_to_ns_scale_factor; no dependencies
package tsc_pkg;

  localparam int unsigned FREQ_W  = 64;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned SHIFT_W = 8;
  // denominator after normalisation stays below 2^31
  localparam int unsigned DEN_W   = 31;
  localparam int unsigned CNT_W   = 5;

  localparam logic [FREQ_W-1:0]         NS_PER_SECOND = 64'd1000000000;
  localparam logic signed [SHIFT_W-1:0] EXP_INIT      = 8'sd32;
  localparam logic [CNT_W-1:0]          DIV_LAST      = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEN_DOWN,
    ST_NUM_UP,
    ST_DEN_FIX,
    ST_NUM_DOWN,
    ST_DIVIDE,
    ST_DELIVER
  } tsc_state_e;

endpackage

@@ rtl/core/tsc_to_ns_scale_factor.sv @@
// top level: normalises 1e9 / tick frequency and divides it into a multiplier and shift
// depends on tsc_pkg and tsc_divider
//
//   channel  signals                                   dir  beat
//   in       in_valid_i / in_stall_o                   in   tick_frequency_i
//   out      out_valid_o / out_stall_i                 out  scale_multiplier_o,
//                                                           scale_shift_o,
//                                                           zero_frequency_error_o
//
// one beat at a time: one normalising shift per cycle (denominator down, numerator
// up, denominator fix, numerator down), then the serial divider; a zero frequency
// skips both and goes straight to delivery
// rst_ni clears the sequencer and the output valid; no clearing pass
// a new beat is taken while the last result still waits on out_stall_i; a finished
// result waits in the sequencer until the output register is free
module tsc_to_ns_scale_factor
  import tsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [FREQ_W-1:0]         tick_frequency_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [MUL_W-1:0]          scale_multiplier_o,
  output logic signed [SHIFT_W-1:0] scale_shift_o,
  output logic                      zero_frequency_error_o
);

  tsc_state_e state_q, state_d;

  logic [FREQ_W-1:0]         num_q, num_d;
  logic [FREQ_W-1:0]         den_q, den_d;
  logic signed [SHIFT_W-1:0] exp_q, exp_d;
  logic                      zero_q, zero_d;

  logic                      out_valid_q, out_valid_d;
  logic [MUL_W-1:0]          mul_q;
  logic signed [SHIFT_W-1:0] shift_q;
  logic                      err_q;

  logic accept;
  logic den_big, num_low, num_lt_den, num_big;
  logic out_free;
  logic div_start, out_load;
  logic div_done;
  logic [MUL_W-1:0] div_quot;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // normalisation tests, den stays below 2^31 after the first phase
  assign den_big    = |den_q[FREQ_W-1:DEN_W];
  assign num_low    = (num_q < {den_q[FREQ_W-DEN_W-1:0], {DEN_W{1'b0}}}) && !num_q[FREQ_W-1];
  assign num_lt_den = (num_q < den_q);
  assign num_big    = (num_q >= {den_q[FREQ_W-MUL_W-1:0], {MUL_W{1'b0}}});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (tick_frequency_i == '0) ? ST_DELIVER : ST_DEN_DOWN;
        end
      end
      ST_DEN_DOWN: begin
        if (!den_big) state_d = ST_NUM_UP;
      end
      ST_NUM_UP: begin
        if (!num_low) state_d = ST_DEN_FIX;
      end
      ST_DEN_FIX: begin
        if (!num_lt_den) state_d = ST_NUM_DOWN;
      end
      ST_NUM_DOWN: begin
        if (!num_big) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:     in_stall_o = 1'b0;
      ST_NUM_DOWN: div_start  = !num_big;
      ST_DELIVER:  out_load   = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // normalisation datapath, one shift per cycle
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    exp_d  = exp_q;
    zero_d = zero_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          num_d  = NS_PER_SECOND;
          den_d  = tick_frequency_i;
          exp_d  = EXP_INIT;
          zero_d = (tick_frequency_i == '0);
        end
      end
      ST_DEN_DOWN: begin
        if (den_big) begin
          den_d = den_q >> 1;
          exp_d = exp_q - SHIFT_W'(1);
        end
      end
      ST_NUM_UP: begin
        if (num_low) begin
          num_d = num_q << 1;
          exp_d = exp_q - SHIFT_W'(1);
        end
      end
      ST_DEN_FIX: begin
        if (num_lt_den) begin
          den_d = den_q >> 1;
          exp_d = exp_q + SHIFT_W'(1);
        end
      end
      ST_NUM_DOWN: begin
        if (num_big) begin
          num_d = num_q >> 1;
          exp_d = exp_q + SHIFT_W'(1);
        end
      end
      default: begin
        num_d = num_q;
      end
    endcase
  end

  // serial quotient
  tsc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q[FREQ_W-2:0]),
    .den_i   (den_q[DEN_W-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    exp_q  <= exp_d;
    zero_q <= zero_d;
  end

  // output register, zero frequency forces both fields to zero
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mul_q   <= zero_q ? '0 : div_quot;
      shift_q <= zero_q ? '0 : exp_q;
      err_q   <= zero_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign scale_multiplier_o     = mul_q;
  assign scale_shift_o          = shift_q;
  assign zero_frequency_error_o = err_q;

endmodule

@@ rtl/core/tsc_divider.sv @@
// restoring divider, one quotient bit per cycle, 63-bit dividend by 31-bit divisor
// the dividend must be below divisor * 2^32; depends on tsc_pkg
module tsc_divider
  import tsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [FREQ_W-2:0]  num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic [MUL_W-1:0]   quot_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [MUL_W-1:0] lo_q, lo_d;
  logic [MUL_W-1:0] quot_q, quot_d;

  logic [MUL_W-1:0] trial;
  logic [MUL_W-1:0] den_ext;
  logic [MUL_W-1:0] diff;
  logic             take;

  // one trial subtraction per cycle
  assign trial   = {rem_q, lo_q[MUL_W-1]};
  assign den_ext = {1'b0, den_q};
  assign take    = (trial >= den_ext);
  assign diff    = trial - den_ext;

  // next-value logic
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = num_i[FREQ_W-2:MUL_W];
      lo_d   = num_i[MUL_W-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_d   = {lo_q[MUL_W-2:0], 1'b0};
      quot_d = {quot_q[MUL_W-2:0], take};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
